>>> sv/stp_pkg.sv
// Shared types, constants and helpers for the stepper step sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stp_pkg;

  localparam int MAX_STEPS_PER_REV_DEF = 1024;

  localparam int SPR_W      = 11;   // steps_per_rev register width
  localparam int INTERVAL_W = 32;   // step_interval register width
  localparam int STEPS_W    = 16;   // remaining-step count
  localparam int ANGLE_W    = 32;
  localparam int POS_W      = 10;   // position field on the result
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [SPR_W-1:0]   SPR_RESET        = 11'd200;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP_MILLI = 32'd1791;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 1'b1;

  // item function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  typedef struct packed {
    logic                       func;
    logic signed [STEPS_W-1:0]  move_steps;
  } in_item_t;

  typedef struct packed {
    logic [3:0]                 coils;
    logic                       stepped;
    logic signed [ANGLE_W-1:0]  angle_milli;
    logic [POS_W-1:0]           position;
    logic                       busy_res;
  } out_item_t;

  // full-step coil pattern by phase
  function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
    logic [3:0] pat;
    case (phase)
      2'd0:    pat = 4'h5;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'hA;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

>>> sv/stepper_step_sequencer_unit.sv
// Four-coil stepper full-step sequencer: one request in, one result out per request.
// Takes one request per clock while the result side keeps up; the single-pass core sets
// that rate. A request is held in the input register, then its result is loaded into
// the result register and offered there until taken. A result held by out_stall keeps
// the input register full, and in_stall is high while that register holds a request
// that cannot move on. Tick requests advance the interval timer one count each.
`timescale 1ns / 1ps

module stepper_step_sequencer_unit #(
  parameter int MAX_STEPS_PER_REV = stp_pkg::MAX_STEPS_PER_REV_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  stp_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output stp_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [stp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import stp_pkg::*;

  localparam int IDX_W = $clog2(MAX_STEPS_PER_REV);
  localparam int N_W   = IDX_W + 1;

  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  logic                  advance;
  logic [N_W-1:0]        rev_n;
  logic [INTERVAL_W-1:0] interval;
  out_item_t             res;

  // stage 1 moves into the result register when that register is free or drains
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  stp_cfg #(
    .MAX_STEPS_PER_REV(MAX_STEPS_PER_REV),
    .N_W              (N_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .rev_n    (rev_n),
    .interval (interval)
  );

  stp_core #(
    .MAX_STEPS_PER_REV(MAX_STEPS_PER_REV),
    .IDX_W            (IDX_W),
    .N_W              (N_W)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .item    (s1_item_r),
    .rev_n   (rev_n),
    .interval(interval),
    .res     (res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> sv/stp_cfg.sv
// Configuration registers of the stepper sequencer and the clamped revolution size.
// Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_cfg #(
  parameter int MAX_STEPS_PER_REV = stp_pkg::MAX_STEPS_PER_REV_DEF,
  parameter int N_W               = $clog2(MAX_STEPS_PER_REV) + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [stp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [N_W-1:0]                    rev_n,
  output logic [stp_pkg::INTERVAL_W-1:0]    interval
);
  import stp_pkg::*;

  localparam int CMP_W = (N_W > SPR_W) ? N_W : SPR_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_STEPS_PER_REV);

  logic [SPR_W-1:0]      spr_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [CMP_W-1:0]      spr_ext;
  logic [CMP_W-1:0]      n_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r      <= SPR_RESET;
      interval_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STEPS_PER_REV: spr_r      <= cfg_wdata[SPR_W-1:0];
        REG_STEP_INTERVAL: interval_r <= cfg_wdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one step, anything above the build limit is capped
  always_comb begin
    spr_ext = CMP_W'(spr_r);
    if (spr_r == '0) begin
      n_c = CMP_W'(1);
    end else if (spr_ext > MAX_C) begin
      n_c = MAX_C;
    end else begin
      n_c = spr_ext;
    end
  end

  assign rev_n    = n_c[N_W-1:0];
  assign interval = interval_r;

endmodule

>>> sv/stp_core.sv
// Step state and next-state logic: move loading, elapsed timer, position,
// angle and coil pattern. Depends on stp_pkg.
`timescale 1ns / 1ps

module stp_core #(
  parameter int MAX_STEPS_PER_REV = stp_pkg::MAX_STEPS_PER_REV_DEF,
  parameter int IDX_W             = $clog2(MAX_STEPS_PER_REV),
  parameter int N_W               = IDX_W + 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  stp_pkg::in_item_t                item,
  input  logic [N_W-1:0]                   rev_n,
  input  logic [stp_pkg::INTERVAL_W-1:0]   interval,
  output stp_pkg::out_item_t               res
);
  import stp_pkg::*;

  logic [STEPS_W-1:0]    steps_left_r, steps_left_nxt;
  logic                  forward_r, forward_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [INTERVAL_W-1:0] elapsed_r, elapsed_nxt;
  logic [ANGLE_W-1:0]    angle_r, angle_nxt;
  logic [3:0]            coil_r, coil_nxt;

  logic [INTERVAL_W-1:0] el_inc;
  logic                  do_step;
  logic [N_W-1:0]        idx_ext;
  logic [N_W-1:0]        idx_p1;
  logic [N_W-1:0]        idx_last;
  logic [IDX_W-1:0]      idx_step;
  logic [POS_W+IDX_W-1:0] pos_ext;

  assign el_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign idx_ext  = N_W'(idx_r);
  assign idx_p1   = idx_ext + 1'b1;
  assign idx_last = rev_n - 1'b1;

  // wrap handles a position left outside a shrunk revolution
  always_comb begin
    if (forward_r) begin
      idx_step = (idx_p1 >= rev_n) ? '0 : idx_p1[IDX_W-1:0];
    end else if (idx_r == '0 || idx_ext > rev_n) begin
      idx_step = idx_last[IDX_W-1:0];
    end else begin
      idx_step = idx_r - 1'b1;
    end
  end

  always_comb begin
    steps_left_nxt = steps_left_r;
    forward_nxt    = forward_r;
    idx_nxt        = idx_r;
    elapsed_nxt    = elapsed_r;
    angle_nxt      = angle_r;
    coil_nxt       = coil_r;
    do_step        = 1'b0;
    if (item.func == FUNC_MOVE) begin
      forward_nxt    = !item.move_steps[STEPS_W-1] && (item.move_steps != '0);
      steps_left_nxt = item.move_steps[STEPS_W-1] ? STEPS_W'(-item.move_steps)
                                                  : STEPS_W'(item.move_steps);
    end else begin
      elapsed_nxt = el_inc;
      if (steps_left_r != '0 && el_inc >= interval) begin
        do_step        = 1'b1;
        elapsed_nxt    = '0;
        steps_left_nxt = steps_left_r - 1'b1;
        idx_nxt        = idx_step;
        angle_nxt      = forward_r ? angle_r + ANGLE_STEP_MILLI
                                   : angle_r - ANGLE_STEP_MILLI;
        coil_nxt       = coil_pattern(idx_step[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r <= '0;
      forward_r    <= 1'b0;
      idx_r        <= '0;
      elapsed_r    <= '0;
      angle_r      <= '0;
      coil_r       <= '0;
    end else if (en) begin
      steps_left_r <= steps_left_nxt;
      forward_r    <= forward_nxt;
      idx_r        <= idx_nxt;
      elapsed_r    <= elapsed_nxt;
      angle_r      <= angle_nxt;
      coil_r       <= coil_nxt;
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, idx_nxt};

  always_comb begin
    res.coils       = coil_nxt;
    res.stepped     = do_step;
    res.angle_milli = angle_nxt;
    res.position    = pos_ext[POS_W-1:0];
    res.busy_res    = (steps_left_nxt != '0);
  end

endmodule

>>> sim/stepper_step_sequencer_unit_tb.sv
// Self-checking testbench for stepper_step_sequencer_unit: directed and random requests,
// results checked against an in-bench motor model. Depends on stp_pkg and the unit RTL.
`timescale 1ns / 1ps

module stepper_step_sequencer_unit_tb;
  import stp_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles with no request or result moving
  localparam int HOLD_CYCLES = 120;
  localparam int REV_MAX     = MAX_STEPS_PER_REV_DEF;
  localparam logic [3:0] PHASE_COILS [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // motor model state and register copies
  logic [STEPS_W-1:0] cur_steps_left;
  logic cur_forward;
  logic [POS_W-1:0] cur_index;
  logic [31:0] cur_elapsed;
  logic [ANGLE_W-1:0] cur_angle;
  logic [3:0] cur_coils;
  logic [SPR_W-1:0] cfg_rev;
  logic [INTERVAL_W-1:0] cfg_interval;

  out_item_t predicted_status [$];
  out_item_t want;
  int mismatches = 0;
  int idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  stepper_step_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted request to the model and queues the status it should produce.
  task automatic advance_motor(input in_item_t req);
    logic [STEPS_W-1:0] raw;
    int n;
    int idx;
    out_item_t res;
    res = '0;
    raw = req.move_steps;
    if (req.func == FUNC_MOVE) begin
      cur_forward = !raw[STEPS_W-1] && (raw != '0);
      cur_steps_left = raw[STEPS_W-1] ? (16'h0000 - raw) : raw;
    end else begin
      if (cur_elapsed != 32'hFFFF_FFFF) cur_elapsed = cur_elapsed + 32'd1;
      if (cur_steps_left != '0 && cur_elapsed >= cfg_interval) begin
        n = (cfg_rev == '0) ? 1 : ((int'(cfg_rev) > REV_MAX) ? REV_MAX : int'(cfg_rev));
        idx = int'(cur_index);
        if (cur_forward) begin
          idx = (idx + 1 >= n) ? 0 : idx + 1;
          cur_angle = cur_angle + ANGLE_STEP_MILLI;
        end else begin
          // an index left past the end by a register change wraps to the last step
          idx = (idx == 0 || idx > n) ? n - 1 : idx - 1;
          cur_angle = cur_angle - ANGLE_STEP_MILLI;
        end
        cur_index = idx[POS_W-1:0];
        cur_coils = PHASE_COILS[idx[1:0]];
        cur_elapsed = '0;
        cur_steps_left = cur_steps_left - 1'b1;
        res.stepped = 1'b1;
      end
    end
    res.coils = cur_coils;
    res.angle_milli = cur_angle;
    res.position = cur_index;
    res.busy_res = (cur_steps_left != '0);
    predicted_status.push_back(res);
  endtask

  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_motor(req);
  endtask

  task automatic send_tick(input logic [STEPS_W-1:0] filler);
    in_item_t req;
    req.func = FUNC_TICK;
    req.move_steps = filler;
    send_req(req);
  endtask

  task automatic send_move(input int steps);
    in_item_t req;
    req.func = FUNC_MOVE;
    req.move_steps = steps[STEPS_W-1:0];
    send_req(req);
  endtask

  function automatic in_item_t rand_req();
    in_item_t req;
    int mag;
    req.move_steps = STEPS_W'($urandom());
    req.func = ($urandom_range(99) < 25) ? FUNC_MOVE : FUNC_TICK;
    // mostly short moves so they finish and busy drops; some full-range counts
    if (req.func == FUNC_MOVE && $urandom_range(9) < 8) begin
      mag = $urandom_range(12);
      req.move_steps = $urandom_range(1) ? mag[STEPS_W-1:0] : -mag[STEPS_W-1:0];
    end
    return req;
  endfunction

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (predicted_status.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_drained(4);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STEPS_PER_REV) cfg_rev = data[SPR_W-1:0];
    else cfg_interval = data;
  endtask

  task automatic test_idle_after_reset();
    send_tick(16'h7FFF);
    send_move(0);
    send_tick(16'h8000);
  endtask

  task automatic test_move_extremes();
    send_move(32767);
    send_tick(16'hFFFF);
    send_move(-32768);
    send_tick(16'h0000);
    send_tick(16'h5555);
  endtask

  task automatic test_step_interval();
    write_reg(REG_STEP_INTERVAL, 32'd2);
    send_move(1);
    send_tick(16'hAAAA);
    send_tick(16'h0001);
    send_tick(16'h0002);
    write_reg(REG_STEP_INTERVAL, 32'hFFFF_FFFF);
    send_move(3);
    send_tick(16'h1234);
    send_tick(16'hFEDC);
    write_reg(REG_STEP_INTERVAL, 32'd0);
  endtask

  task automatic test_revolution_bounds();
    write_reg(REG_STEPS_PER_REV, 32'd0);      // zero size acts as one step
    send_move(2);
    send_tick(16'h0000);
    send_tick(16'h0000);
    write_reg(REG_STEPS_PER_REV, 32'd2047);   // clamps to the maximum
    send_move(-1);
    send_tick(16'h0000);
    write_reg(REG_STEPS_PER_REV, 32'd4);      // index now past the end, forward
    send_move(1);
    send_tick(16'h0000);
    write_reg(REG_STEPS_PER_REV, 32'd2047);
    send_move(-2);
    send_tick(16'h0000);
    send_tick(16'h0000);
    write_reg(REG_STEPS_PER_REV, 32'd4);      // past the end, reverse
    send_move(-1);
    send_tick(16'h0000);
    write_reg(REG_STEPS_PER_REV, 32'd200);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_ask = hold_ask + 1;
    repeat (40) send_req(rand_req());
    wait_drained(4);
  endtask

  task automatic test_random_traffic(input int count, input int unsigned s_pct,
                                     input int unsigned r_pct);
    logic [31:0] rev;
    logic [31:0] ivl;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int seg = 0; seg < 4; seg++) begin
      case ($urandom_range(7))
        0: rev = 32'd0;
        1: rev = 32'd1;
        2: rev = 32'd4;
        3: rev = 32'd1024;
        4: rev = 32'd2047;
        default: rev = $urandom_range(2047);
      endcase
      case ($urandom_range(7))
        0: ivl = 32'hFFFF_FFFF;
        1: ivl = 32'd0;
        default: ivl = $urandom_range(6);
      endcase
      write_reg(REG_STEPS_PER_REV, rev);
      write_reg(REG_STEP_INTERVAL, ivl);
      repeat (count / 4) send_req(rand_req());
    end
  endtask

  // receiver: random stalls, or a long hold-off when the test asks for one
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt = hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: coils=%h stepped=%b angle=%0d pos=%0d busy=%b",
                   out_item.coils, out_item.stepped, out_item.angle_milli,
                   out_item.position, out_item.busy_res);
      end else begin
        want = predicted_status.pop_front();
        if (out_item.coils !== want.coils || out_item.stepped !== want.stepped ||
            out_item.angle_milli !== want.angle_milli ||
            out_item.position !== want.position || out_item.busy_res !== want.busy_res) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp coils=%h stepped=%b angle=%0d pos=%0d busy=%b",
                     want.coils, want.stepped, want.angle_milli, want.position,
                     want.busy_res);
            $display("          got coils=%h stepped=%b angle=%0d pos=%0d busy=%b",
                     out_item.coils, out_item.stepped, out_item.angle_milli,
                     out_item.position, out_item.busy_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cur_steps_left = '0;
    cur_forward = 1'b0;
    cur_index = '0;
    cur_elapsed = '0;
    cur_angle = '0;
    cur_coils = '0;
    cfg_rev = SPR_RESET;
    cfg_interval = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_stall_pct = 81;
    test_idle_after_reset();
    test_move_extremes();
    test_step_interval();
    test_revolution_bounds();
    test_random_traffic(490, 27, 81);
    test_random_traffic(490, 81, 27);
    test_random_traffic(490, 0, 0);
    test_backpressure();

    wait_drained(10);
    mismatches += predicted_status.size();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> stepper_step_sequencer_unit.f
sv/stp_pkg.sv
sv/stp_cfg.sv
sv/stp_core.sv
sv/stepper_step_sequencer_unit.sv
sim/stepper_step_sequencer_unit_tb.sv
